// ===== hdl/nspd_pkg.sv =====
// Shared types, constants and register codes of the spike peak detector.
package nspd_pkg;

  // Number of tracked neurons and the width of a neuron index.
  localparam int unsigned NEURONS  = 256;
  localparam int unsigned NEURON_W = $clog2(NEURONS);

  // Width of the configuration register index.
  localparam int unsigned CFG_IDX_W = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_THRESHOLD     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_THRESHOLD = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_STEPS         = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REST_VOLTAGE       = 8'd3;

  // Phase codes as stored per neuron and reported in each result.
  localparam logic [1:0] PH_FALLING = 2'd0;
  localparam logic [1:0] PH_RISING  = 2'd1;
  localparam logic [1:0] PH_PEAKED  = 2'd2;

  // Reset values of the registers (Q8.8 mV where signed).
  localparam logic [15:0] PEAK_THRESHOLD_RESET     = 16'h0000;
  localparam logic [15:0] COOLDOWN_THRESHOLD_RESET = 16'hD800;
  localparam logic [23:0] SKIP_STEPS_RESET         = 24'h000000;
  localparam logic [15:0] REST_VOLTAGE_RESET       = 16'hBF00;

  // Saturation limit of the peak counter.
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // One input item.
  typedef struct packed {
    logic [NEURON_W-1:0] neuron;
    logic signed [15:0]  voltage;
    logic [23:0]         step;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic        peak_now;
    logic [1:0]  phase;
    logic [15:0] peak_count;
    logic [23:0] first_peak_step;
    logic [23:0] last_peak_step;
  } out_item_t;

  // State held for one neuron in the state memory.
  typedef struct packed {
    logic [1:0]         phase;
    logic signed [15:0] prev_voltage;
    logic [15:0]        count;
    logic [23:0]        first_step;
    logic [23:0]        last_step;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Contents of an entry that has not been written since reset.
  localparam entry_t ENTRY_RESET = '{
    phase:        PH_FALLING,
    prev_voltage: REST_VOLTAGE_RESET,
    count:        16'h0000,
    first_step:   24'h000000,
    last_step:    24'h000000
  };

  // Configuration registers that the update logic uses.
  typedef struct packed {
    logic signed [15:0] peak_threshold;
    logic signed [15:0] cooldown_threshold;
    logic [23:0]        skip_steps;
  } cfg_t;

endpackage

// ===== hdl/nspd_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module nspd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Read returns the old contents when the same entry is written in the same cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/nspd_update.sv =====
// Next-state and result logic for one sample applied to one neuron entry.
module nspd_update (
  input  nspd_pkg::in_item_t  item_i,
  input  nspd_pkg::entry_t    cur_i,
  input  nspd_pkg::cfg_t      cfg_i,
  output nspd_pkg::entry_t    nxt_o,
  output nspd_pkg::out_item_t res_o
);

  logic       active;
  logic       peak;
  logic [1:0] phase;

  assign active = item_i.step > cfg_i.skip_steps;

  // Phase tracker with peak bookkeeping; skipped steps only refresh the voltage.
  always_comb begin
    nxt_o              = cur_i;
    nxt_o.prev_voltage = item_i.voltage;
    peak               = 1'b0;
    phase              = cur_i.phase;
    if (active) begin
      case (cur_i.phase)
        nspd_pkg::PH_PEAKED: begin
          if ($signed(item_i.voltage) < $signed(cfg_i.cooldown_threshold)) begin
            phase = nspd_pkg::PH_FALLING;
          end
        end
        nspd_pkg::PH_RISING: begin
          if (($signed(item_i.voltage) > $signed(cfg_i.peak_threshold)) &&
              ($signed(item_i.voltage) < $signed(cur_i.prev_voltage))) begin
            peak  = 1'b1;
            phase = nspd_pkg::PH_PEAKED;
            if (cur_i.count != nspd_pkg::COUNT_MAX) begin
              nxt_o.count = cur_i.count + 16'd1;
            end
            if (cur_i.first_step == 24'd0) begin
              nxt_o.first_step = item_i.step;
            end else begin
              nxt_o.last_step = item_i.step;
            end
          end
        end
        default: begin
          // Falling, and the unused code, which behaves as falling.
          if ($signed(item_i.voltage) > $signed(cur_i.prev_voltage)) begin
            phase = nspd_pkg::PH_RISING;
          end else begin
            phase = nspd_pkg::PH_FALLING;
          end
        end
      endcase
      nxt_o.phase = phase;
    end
  end

  // The result reports the entry as it stands after this sample.
  always_comb begin
    res_o.peak_now        = peak;
    res_o.phase           = phase;
    res_o.peak_count      = nxt_o.count;
    res_o.first_peak_step = nxt_o.first_step;
    res_o.last_peak_step  = nxt_o.last_step;
  end

endmodule

// ===== hdl/neuron_spike_peak_detector.sv =====
// Top level of the spike peak detector: config registers, state RAM pipeline and result register.
//
// The block takes one sample item per clock cycle while in_stall_o is low; each result passes
// through the update stage and the output register. The design rests on the read-modify-write of
// one 82-bit entry in the 256-entry state RAM: the entry is read in the cycle of acceptance,
// updated and written back when the update stage advances, and a forwarding register supplies
// the just-written entry when consecutive samples address the same neuron. Per-entry valid flags,
// cleared at reset, make unwritten entries read as their reset contents, so the block is ready
// at once after reset with no clearing pass. A write to rest_voltage is accepted but has no
// effect; unwritten entries always use the fixed reset value of the rest voltage.
module neuron_spike_peak_detector (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  nspd_pkg::in_item_t                   in_item_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output nspd_pkg::out_item_t                  out_item_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [nspd_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [23:0]                          cfg_data_i
);

  nspd_pkg::cfg_t      cfg_q;
  logic                in_acc;
  logic                s1_adv;
  logic                s1_valid_q;
  nspd_pkg::in_item_t  s1_item_q;
  logic [nspd_pkg::ENTRY_W-1:0] ram_rdata;
  nspd_pkg::entry_t    cur_entry;
  nspd_pkg::entry_t    nxt_entry;
  nspd_pkg::out_item_t res;
  logic                fwd_valid_q;
  logic [nspd_pkg::NEURON_W-1:0] fwd_addr_q;
  nspd_pkg::entry_t    fwd_entry_q;
  logic [nspd_pkg::NEURONS-1:0]  written_q;
  logic                out_valid_q;
  nspd_pkg::out_item_t out_item_q;

  // Configuration registers; the port never holds a write off.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.peak_threshold     <= nspd_pkg::PEAK_THRESHOLD_RESET;
      cfg_q.cooldown_threshold <= nspd_pkg::COOLDOWN_THRESHOLD_RESET;
      cfg_q.skip_steps         <= nspd_pkg::SKIP_STEPS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        nspd_pkg::CFG_PEAK_THRESHOLD:     cfg_q.peak_threshold     <= cfg_data_i[15:0];
        nspd_pkg::CFG_COOLDOWN_THRESHOLD: cfg_q.cooldown_threshold <= cfg_data_i[15:0];
        nspd_pkg::CFG_SKIP_STEPS:         cfg_q.skip_steps         <= cfg_data_i;
        // The rest voltage only matters at reset, where its reset value is used.
        nspd_pkg::CFG_REST_VOLTAGE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Handshake: the update stage moves on whenever the output register is free or draining.
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Update stage holding the sample whose entry is being read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q <= in_item_i;
    end
  end

  // State memory: read at acceptance, written back when the update stage advances.
  nspd_ram #(
    .Width (nspd_pkg::ENTRY_W),
    .Depth (nspd_pkg::NEURONS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_item_q.neuron),
    .wdata_i (nxt_entry),
    .re_i    (in_acc),
    .raddr_i (in_item_i.neuron),
    .rdata_o (ram_rdata)
  );

  // Entry source: the last write if it hit this neuron, else memory or the reset contents.
  always_comb begin
    if (fwd_valid_q && (fwd_addr_q == s1_item_q.neuron)) begin
      cur_entry = fwd_entry_q;
    end else if (written_q[s1_item_q.neuron]) begin
      cur_entry = nspd_pkg::entry_t'(ram_rdata);
    end else begin
      cur_entry = nspd_pkg::ENTRY_RESET;
    end
  end

  nspd_update u_update (
    .item_i (s1_item_q),
    .cur_i  (cur_entry),
    .cfg_i  (cfg_q),
    .nxt_o  (nxt_entry),
    .res_o  (res)
  );

  // Forwarding register and per-entry written flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
      written_q   <= '0;
    end else if (s1_adv) begin
      fwd_valid_q                  <= 1'b1;
      written_q[s1_item_q.neuron]  <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      fwd_addr_q  <= s1_item_q.neuron;
      fwd_entry_q <= nxt_entry;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // The input is held off only by a full, stalled output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked result");

  // A reported peak leaves the neuron peaked with a counted peak and a first step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.peak_now) |->
      ((out_item_o.phase == nspd_pkg::PH_PEAKED) && (out_item_o.peak_count != 16'd0) &&
       (out_item_o.first_peak_step != 24'd0)))
    else $error("peak reported with inconsistent entry");

  // An accepted item occupies the update stage in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s1_valid_q)
    else $error("accepted item lost before update");

  // A written-back entry is available for forwarding in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> (fwd_valid_q && (fwd_addr_q == $past(s1_item_q.neuron))))
    else $error("forwarding register missed a write-back");

endmodule
